### hw/rtl/xcts_pkg.sv
// Shared types, constants and decode helpers of the call target scanner.
package xcts_pkg;

	typedef enum logic [2:0] {
		PH_START,
		PH_PREFIX,
		PH_MODRM,
		PH_SKIP,
		PH_CALL
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic [11:0] off;
		phase_t      phase;
		logic [3:0]  skip;
		logic [7:0]  pend;
		logic [11:0] call_off;
		logic [31:0] disp;
	} dec_state_t;

	typedef struct packed {
		logic        call_start;
		logic        call_done;
		logic        done;
	} dec_flags_t;

	localparam logic [2:0] CFG_WINDOW_BASE   = 3'd0;
	localparam logic [2:0] CFG_WINDOW_LENGTH = 3'd1;
	localparam logic [2:0] CFG_CODE_LOW      = 3'd2;
	localparam logic [2:0] CFG_CODE_HIGH     = 3'd3;
	localparam logic [2:0] CFG_EXCLUDE_LOW   = 3'd4;
	localparam logic [2:0] CFG_EXCLUDE_HIGH  = 3'd5;
	localparam logic [2:0] CFG_MAX_TARGETS   = 3'd6;

	localparam logic [7:0]  OP_CALL    = 8'hE8;
	localparam logic [7:0]  MOD_MASK   = 8'hC0;
	localparam logic [11:0] OFF_SAT    = 12'd4095;

	localparam logic [31:0] RST_WINDOW_BASE   = 32'h0000_0000;
	localparam logic [11:0] RST_WINDOW_LENGTH = 12'd600;
	localparam logic [31:0] RST_CODE_LOW      = 32'h0040_1000;
	localparam logic [31:0] RST_CODE_HIGH     = 32'h009D_E3B3;
	localparam logic [31:0] RST_EXCLUDE_LOW   = 32'h0084_C000;
	localparam logic [31:0] RST_EXCLUDE_HIGH  = 32'h0086_1000;
	localparam logic [4:0]  RST_MAX_TARGETS   = 5'd16;

	function automatic logic is_prefix(input logic [7:0] b);
		return b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E || b == 8'h36 ||
			b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65 || b == 8'h66 ||
			b == 8'h67;
	endfunction

	// total length of a fixed-length opcode, 0 when a ModRM byte follows
	function automatic logic [2:0] fixed_length(input logic [7:0] op);
		if ((op >= 8'h50 && op <= 8'h5F) || (op >= 8'h90 && op <= 8'h99) ||
			(op >= 8'h9C && op <= 8'h9F) || (op >= 8'hAA && op <= 8'hAF) ||
			op == 8'hCC || op == 8'hCE || op == 8'hCF || op == 8'hC3 ||
			op == 8'hC9 || (op >= 8'hEB && op <= 8'hEF) || op == 8'hF4 ||
			op == 8'hF5 || (op >= 8'hF8 && op <= 8'hFD))
			return 3'd1;
		if ((op >= 8'hB0 && op <= 8'hB7) || (op >= 8'hE4 && op <= 8'hE7) ||
			op == 8'h6A || op == 8'h0F || (op >= 8'hD0 && op <= 8'hD3))
			return 3'd2;
		if ((op >= 8'hB8 && op <= 8'hBF) || op == 8'hE8 || op == 8'hE9 ||
			op == 8'h68 || (op >= 8'hA0 && op <= 8'hA3))
			return 3'd5;
		return 3'd0;
	endfunction

	// bytes that follow the ModRM byte
	function automatic logic [3:0] after_modrm(input logic [7:0] op, input logic [7:0] m);
		logic [7:0] md;
		logic [2:0] rm;
		logic       grp;
		logic [3:0] extra;
		md    = m & MOD_MASK;
		rm    = m[2:0];
		grp   = op == 8'hC0 || op == 8'hC1 || op == 8'hC6 || op == 8'hC7;
		extra = 4'd0;
		if (md == 8'h40)
			extra = 4'd1;
		else if (md == 8'h80)
			extra = 4'd4;
		else if (md == 8'h00) begin
			if (rm == 3'd5)
				extra = 4'd4;
			else if (rm == 3'd4 && !grp)
				extra = 4'd1;
		end
		if (grp)
			extra = extra + ((op == 8'hC7) ? 4'd4 : 4'd1);
		return extra;
	endfunction

endpackage

### hw/rtl/xcts_in_if.sv
// Input channel: one code byte per beat.
interface xcts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       first_byte;

	modport source (output valid, output code_byte, output first_byte, input ready);
	modport sink (input valid, input code_byte, input first_byte, output ready);
endinterface

### hw/rtl/xcts_out_if.sv
// Output channel: one target or window-done result per beat.
interface xcts_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] target_address;
	logic [4:0]  target_count;

	modport source (output valid, output result_kind, output target_address,
		output target_count, input ready);
	modport sink (input valid, input result_kind, input target_address,
		input target_count, output ready);
endinterface

### hw/rtl/xcts_decode.sv
// Length decoder step: next decode state for one code byte.
module xcts_decode import xcts_pkg::*; (
	input  dec_state_t  cur,
	input  logic [7:0]  code_byte,
	input  logic        first_byte,
	input  logic [11:0] win_len,
	input  logic        raw_ok,
	output dec_state_t  nxt,
	output dec_flags_t  flags
);

	dec_state_t  s;
	logic [12:0] off_p5;
	logic [2:0]  flen;
	logic [3:0]  mlen;
	logic [3:0]  skip_dec;

	always_comb begin
		s = first_byte ? dec_state_t'{off: 12'd0, phase: PH_START, skip: 4'd0, pend: 8'd0,
			call_off: 12'd0, disp: 32'd0} : cur;
		nxt      = s;
		flags    = '0;
		off_p5   = {1'b0, s.off} + 13'd5;
		flen     = fixed_length(code_byte);
		mlen     = after_modrm(s.pend, code_byte);
		skip_dec = (s.skip != 4'd0) ? s.skip - 4'd1 : 4'd0;
		if (s.off < win_len) begin
			case (s.phase)
				PH_START: begin
					if (off_p5 < {1'b0, win_len} && raw_ok) begin
						if (code_byte == OP_CALL) begin
							flags.call_start = 1'b1;
							nxt.call_off = s.off;
							nxt.disp     = 32'd0;
							nxt.skip     = 4'd4;
							nxt.phase    = PH_CALL;
						end else if (is_prefix(code_byte)) begin
							nxt.phase = PH_PREFIX;
						end else if (flen != 3'd0) begin
							nxt.skip  = {1'b0, flen - 3'd1};
							nxt.phase = (flen == 3'd1) ? PH_START : PH_SKIP;
						end else begin
							nxt.pend  = code_byte;
							nxt.phase = PH_MODRM;
						end
					end
				end
				PH_PREFIX: begin
					if (!is_prefix(code_byte)) begin
						if (flen != 3'd0) begin
							nxt.skip  = {1'b0, flen - 3'd1};
							nxt.phase = (flen == 3'd1) ? PH_START : PH_SKIP;
						end else begin
							nxt.pend  = code_byte;
							nxt.phase = PH_MODRM;
						end
					end
				end
				PH_MODRM: begin
					nxt.skip  = mlen;
					nxt.phase = (mlen == 4'd0) ? PH_START : PH_SKIP;
				end
				PH_SKIP: begin
					nxt.skip = skip_dec;
					if (skip_dec == 4'd0)
						nxt.phase = PH_START;
				end
				PH_CALL: begin
					nxt.disp = {code_byte, s.disp[31:8]};
					nxt.skip = skip_dec;
					if (skip_dec == 4'd0) begin
						nxt.phase       = PH_START;
						flags.call_done = 1'b1;
					end
				end
				default: nxt.phase = PH_START;
			endcase
			flags.done = (s.off + 12'd1) == win_len;
		end
		nxt.off = (s.off < OFF_SAT) ? s.off + 12'd1 : s.off;
	end

endmodule

### hw/rtl/xcts_dedupe.sv
// Target store with a single comparator that walks the held entries.
module xcts_dedupe import xcts_pkg::*; #(
	parameter int MAX_FOUND = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [31:0]                                 target,
	input  logic [$clog2(MAX_FOUND+1)-1:0]              count,
	input  logic                                        wr_en,
	output logic                                        fin,
	output logic                                        hit
);

	localparam int CNTW = $clog2(MAX_FOUND + 1);
	localparam int IDXW = (MAX_FOUND > 1) ? $clog2(MAX_FOUND) : 1;

	logic [31:0]     mem [MAX_FOUND];
	logic [31:0]     rd_q;
	logic [IDXW-1:0] rd_addr;
	logic [CNTW-1:0] k_q;
	logic [CNTW-1:0] k_nxt;
	logic            active_q;
	logic            fin_q;
	logic            hit_q;
	logic            match;
	logic            last;

	assign k_nxt   = k_q + CNTW'(1);
	assign match   = rd_q == target;
	assign last    = k_nxt == count;
	assign rd_addr = start ? IDXW'(0) : IDXW'(k_nxt);

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_en)
			mem[IDXW'(count)] <= target;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			fin_q    <= 1'b0;
			hit_q    <= 1'b0;
			k_q      <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				k_q <= '0;
				if (count == '0) begin
					fin_q <= 1'b1;
					hit_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
				end
			end else if (active_q) begin
				// entry k is in rd_q, entry k+1 is being read
				if (match || last) begin
					active_q <= 1'b0;
					fin_q    <= 1'b1;
					hit_q    <= match;
				end else begin
					k_q <= k_nxt;
				end
			end
		end
	end

	assign fin = fin_q;
	assign hit = hit_q;

endmodule

### hw/rtl/x86_call_target_scanner_core.sv
// Top level of the x86 call target scanner.
// Takes one code byte per input beat and runs a simplified x86 length decoder over the
// window; an unprefixed E8 call yields target = window_base + offset + 5 + rel32. Each
// byte beat yields at most one result. A byte that completes a call goes through target
// add and range check; a target in range starts the store, is walked past the targets
// already held through a single 32-bit comparator over the dedupe store and, if new or
// at window end, loads the output register; a byte that only ends the window loads it.
// Input ready is high only while the sequencer is idle. The output register lets the next
// byte enter while an earlier result is still unread. Configuration is written through
// cfg_we/cfg_index/cfg_data; write it only while idle, the block does not enforce this.
module x86_call_target_scanner_core import xcts_pkg::*; #(
	parameter int MAX_RAW_CALLS = 48,
	parameter int MAX_FOUND     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	xcts_in_if.sink     in_ch,
	xcts_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CNTW = $clog2(MAX_FOUND + 1);
	localparam int RAWW = $clog2(MAX_RAW_CALLS + 1);

	// configuration
	logic [31:0] window_base_q, code_low_q, code_high_q, exclude_low_q, exclude_high_q;
	logic [11:0] window_length_q;
	logic [4:0]  max_targets_q;

	// decode and window state
	dec_state_t      dec_q, dec_nxt;
	dec_flags_t      flags;
	logic [RAWW-1:0] raw_q;
	logic [CNTW-1:0] count_q;
	logic            raw_ok;
	logic            done_q;
	logic [31:0]     t_q;

	// sequencer
	ctl_state_t state_q, state_nxt;
	logic       in_beat, out_free;
	logic       check_ok, start_scan, store_wr;
	logic       fin, hit;
	logic [5:0] limit;

	// output register
	logic        out_valid_q;
	logic        out_kind_q;
	logic [31:0] out_addr_q;
	logic [4:0]  out_cnt_q;

	assign in_beat  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign raw_ok   = in_ch.first_byte || (raw_q < RAWW'(MAX_RAW_CALLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q   <= RST_WINDOW_BASE;
			window_length_q <= RST_WINDOW_LENGTH;
			code_low_q      <= RST_CODE_LOW;
			code_high_q     <= RST_CODE_HIGH;
			exclude_low_q   <= RST_EXCLUDE_LOW;
			exclude_high_q  <= RST_EXCLUDE_HIGH;
			max_targets_q   <= RST_MAX_TARGETS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_BASE:   window_base_q   <= cfg_data;
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data[11:0];
				CFG_CODE_LOW:      code_low_q      <= cfg_data;
				CFG_CODE_HIGH:     code_high_q     <= cfg_data;
				CFG_EXCLUDE_LOW:   exclude_low_q   <= cfg_data;
				CFG_EXCLUDE_HIGH:  exclude_high_q  <= cfg_data;
				CFG_MAX_TARGETS:   max_targets_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	xcts_decode u_decode (
		.cur        (dec_q),
		.code_byte  (in_ch.code_byte),
		.first_byte (in_ch.first_byte),
		.win_len    (window_length_q),
		.raw_ok     (raw_ok),
		.nxt        (dec_nxt),
		.flags      (flags)
	);

	// target limit is min(max_targets, MAX_FOUND)
	assign limit = ({1'b0, max_targets_q} < 6'(MAX_FOUND)) ? {1'b0, max_targets_q}
		: 6'(MAX_FOUND);
	assign check_ok = (6'(count_q) < limit) && (t_q >= code_low_q) && (t_q <= code_high_q)
		&& !((t_q >= exclude_low_q) && (t_q <= exclude_high_q));
	assign start_scan = (state_q == ST_CHECK) && check_ok;
	assign store_wr   = (state_q == ST_SCAN) && fin && !hit;

	xcts_dedupe #(.MAX_FOUND(MAX_FOUND)) u_dedupe (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_scan),
		.target (t_q),
		.count  (count_q),
		.wr_en  (store_wr),
		.fin    (fin),
		.hit    (hit)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					if (flags.call_done)
						state_nxt = ST_CALC;
					else if (flags.done)
						state_nxt = ST_EMIT;
				end
			end
			ST_CALC: state_nxt = ST_CHECK;
			ST_CHECK: begin
				if (check_ok)
					state_nxt = ST_SCAN;
				else if (done_q)
					state_nxt = ST_EMIT;
				else
					state_nxt = ST_IDLE;
			end
			ST_SCAN: begin
				if (fin) begin
					if (!hit || done_q)
						state_nxt = ST_EMIT;
					else
						state_nxt = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready = 1'b0;
		case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			default: in_ch.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dec_q       <= '{off: 12'd0, phase: PH_START, skip: 4'd0, pend: 8'd0,
				call_off: 12'd0, disp: 32'd0};
			raw_q       <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_beat) begin
				dec_q  <= dec_nxt;
				done_q <= flags.done;
				if (in_ch.first_byte) begin
					raw_q   <= RAWW'(flags.call_start);
					count_q <= '0;
				end else if (flags.call_start) begin
					raw_q <= raw_q + RAWW'(1);
				end
			end
			if (store_wr)
				count_q <= count_q + CNTW'(1);
			if (out_ch.ready)
				out_valid_q <= 1'b0;
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC)
			t_q <= window_base_q + {20'd0, dec_q.call_off} + 32'd5 + dec_q.disp;
		if (state_q == ST_EMIT && out_free) begin
			out_kind_q <= done_q;
			out_addr_q <= done_q ? 32'd0 : t_q;
			out_cnt_q  <= 5'(count_q);
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.result_kind    = out_kind_q;
	assign out_ch.target_address = out_addr_q;
	assign out_ch.target_count   = out_cnt_q;

endmodule

### hw/rtl/xcts_checker.sv
// Port-level checks of the scanner and their bind.
module xcts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_kind,
	input logic [31:0] out_addr,
	input logic [4:0]  out_cnt
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_addr) && $stable(out_kind))
		else $error("stalled result changed");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> out_addr == 32'd0)
		else $error("done result carries an address");

	a_target_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> out_cnt != 5'd0)
		else $error("target result with zero count");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while input side idle");

endmodule

bind x86_call_target_scanner_core xcts_checker u_xcts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_kind  (out_ch.result_kind),
	.out_addr  (out_ch.target_address),
	.out_cnt   (out_ch.target_count)
);
